@@ hw/rtl/bmp_rle_pixel_decoder_unit_assert.svh @@
// Assertion macros for the decoder RTL; only the back end includes them.
// Depends on nothing; files that assert pull this in by include.
`ifndef BMP_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define BMP_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define BMPRLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("bmprle assertion failed");
`define BMPRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("bmprle assertion failed");
`else
`define BMPRLE_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BMPRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hw/rtl/bmprle_pkg.sv @@
// Shared types, constants and helpers for the BMP RLE pixel decoder.
// No dependencies.
package bmprle_pkg;

	localparam int COORD_BITS    = 16;
	localparam int CMP_BITS      = (COORD_BITS > 16) ? COORD_BITS : 16;
	localparam int CMDQ_DEPTH    = 2;
	localparam int CMDQ_PTR_BITS = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_BITS = $clog2(CMDQ_DEPTH + 1);
	localparam int OUT_DATA_BITS = 56;
	localparam int CFG_IDX_BITS  = 1;

	localparam logic [7:0] ESC_EOL   = 8'h00;
	localparam logic [7:0] ESC_EOD   = 8'h01;
	localparam logic [7:0] ESC_DELTA = 8'h02;
	localparam logic [3:0] NIB_MASK  = 4'h0f;

	localparam logic [CFG_IDX_BITS-1:0] REG_NIBBLE_MODE  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_SEG,
		CMD_EOL,
		CMD_DONE,
		CMD_DX,
		CMD_DY
	} cmd_kind_t;

	// one classified byte; v1 doubles as the delta argument
	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] len;
		logic [7:0] v1;
		logic [3:0] v2;
	} cmd_t;

	typedef logic [COORD_BITS-1:0] coord_t;

	function automatic coord_t sat_add(input coord_t a, input logic [7:0] b);
		logic [COORD_BITS:0] s;
		s = {1'b0, a} + (COORD_BITS+1)'(b);
		return s[COORD_BITS] ? '1 : s[COORD_BITS-1:0];
	endfunction

endpackage

@@ hw/rtl/bmprle_front.sv @@
// Front end: tracks the escape/run grammar and turns each byte into a command.
// Depends on bmprle_pkg.
module bmprle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [7:0]         code_byte,
	input  logic               nibble_mode,
	output bmprle_pkg::cmd_t   cmd
);
	import bmprle_pkg::*;

	typedef enum logic [7:0] {
		PH_COUNT  = 8'b0000_0001,
		PH_VALUE  = 8'b0000_0010,
		PH_ESCAPE = 8'b0000_0100,
		PH_DX     = 8'b0000_1000,
		PH_DY     = 8'b0001_0000,
		PH_ABS    = 8'b0010_0000,
		PH_PAD    = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] pend_q, pend_d;
	logic [7:0] left_q, left_d;
	logic       pad_q, pad_d;
	logic [7:0] abs_len;
	logic [3:0] hi_nib, lo_nib;

	assign hi_nib  = code_byte[7:4];
	assign lo_nib  = code_byte[3:0] & NIB_MASK;
	assign abs_len = nibble_mode ? ((left_q >= 8'd2) ? 8'd2 : left_q) : 8'd1;

	always_comb begin
		phase_d  = phase_q;
		pend_d   = pend_q;
		left_d   = left_q;
		pad_d    = pad_q;
		cmd.kind = CMD_NOP;
		cmd.len  = 8'd0;
		cmd.v1   = code_byte;
		cmd.v2   = 4'd0;
		unique case (phase_q)
			PH_COUNT: begin
				if (code_byte != 8'd0) begin
					pend_d  = code_byte;
					phase_d = PH_VALUE;
				end else begin
					phase_d = PH_ESCAPE;
				end
			end
			PH_VALUE: begin
				phase_d  = PH_COUNT;
				cmd.kind = CMD_SEG;
				cmd.len  = pend_q;
				if (nibble_mode) begin
					cmd.v1 = {4'd0, hi_nib};
					cmd.v2 = lo_nib;
				end
			end
			PH_ESCAPE: begin
				priority if (code_byte == ESC_EOL) begin
					cmd.kind = CMD_EOL;
					phase_d  = PH_COUNT;
				end else if (code_byte == ESC_EOD) begin
					cmd.kind = CMD_DONE;
					phase_d  = PH_DONE;
				end else if (code_byte == ESC_DELTA) begin
					phase_d = PH_DX;
				end else begin
					left_d  = code_byte;
					// RLE4 pads when count mod 4 is 1 or 2
					pad_d   = nibble_mode ? (code_byte[1] ^ code_byte[0]) : code_byte[0];
					phase_d = PH_ABS;
				end
			end
			PH_DX: begin
				cmd.kind = CMD_DX;
				phase_d  = PH_DY;
			end
			PH_DY: begin
				cmd.kind = CMD_DY;
				phase_d  = PH_COUNT;
			end
			PH_ABS: begin
				cmd.kind = CMD_SEG;
				cmd.len  = abs_len;
				if (nibble_mode) begin
					cmd.v1 = {4'd0, hi_nib};
					cmd.v2 = lo_nib;
				end
				left_d = left_q - abs_len;
				if (left_d == 8'd0)
					phase_d = pad_q ? PH_PAD : PH_COUNT;
			end
			PH_PAD: begin
				pad_d   = 1'b0;
				phase_d = PH_COUNT;
			end
			PH_DONE: ;
			default: phase_d = PH_COUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COUNT;
			pend_q  <= 8'd0;
			left_q  <= 8'd0;
			pad_q   <= 1'b0;
		end else if (push) begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			left_q  <= left_d;
			pad_q   <= pad_d;
		end
	end

endmodule

@@ hw/rtl/bmprle_fifo.sv @@
// Short command queue between front and back end.
// Depends on bmprle_pkg.
module bmprle_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bmprle_pkg::cmd_t push_cmd,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output bmprle_pkg::cmd_t head
);
	import bmprle_pkg::*;

	cmd_t                     mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_BITS-1:0] cnt_q;

	assign full      = (cnt_q == CMDQ_CNT_BITS'(CMDQ_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [CMDQ_PTR_BITS-1:0] ptr_inc(input logic [CMDQ_PTR_BITS-1:0] p);
		return (p == CMDQ_PTR_BITS'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ hw/rtl/bmprle_back.sv @@
// Back end: owns column/line position, height check and the output register.
// Depends on bmprle_pkg and the assertion macro header.
`include "bmp_rle_pixel_decoder_unit_assert.svh"
module bmprle_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  bmprle_pkg::cmd_t cmd,
	output logic             pop,
	input  logic [15:0]      image_height,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [15:0]      out_row,
	output logic [15:0]      out_column,
	output logic [7:0]       out_len,
	output logic [7:0]       out_first,
	output logic [3:0]       out_second,
	output logic             out_done
);
	import bmprle_pkg::*;

	coord_t              col_q, col_d;
	coord_t              line_q, line_d;
	coord_t              line_step;
	coord_t              row_coord;
	logic [CMP_BITS-1:0] row_w;
	logic                done_q, done_d;
	logic                line_ge, step_ge;
	logic                emit;
	logic [15:0]         o_row, o_col;
	logic [7:0]          o_len, o_first;
	logic [3:0]          o_second;
	logic                o_done;

	logic                out_vld_q;
	logic [15:0]         out_row_q, out_col_q;
	logic [7:0]          out_len_q, out_first_q;
	logic [3:0]          out_second_q;
	logic                out_done_q;

	assign pop       = cmd_valid && (!out_vld_q || out_ready);
	assign line_ge   = CMP_BITS'(line_q) >= CMP_BITS'(image_height);
	assign line_step = sat_add(line_q, (cmd.kind == CMD_EOL) ? 8'd1 : cmd.v1);
	assign step_ge   = CMP_BITS'(line_step) >= CMP_BITS'(image_height);
	assign row_w     = CMP_BITS'(image_height) - CMP_BITS'(1) - CMP_BITS'(line_q);
	assign row_coord = row_w[COORD_BITS-1:0];

	always_comb begin
		col_d    = col_q;
		line_d   = line_q;
		done_d   = done_q;
		emit     = 1'b0;
		o_row    = 16'd0;
		o_col    = 16'd0;
		o_len    = 8'd0;
		o_first  = 8'd0;
		o_second = 4'd0;
		o_done   = 1'b0;
		if (!done_q) begin
			if (line_ge) begin
				emit   = 1'b1;
				o_done = 1'b1;
				done_d = 1'b1;
			end else begin
				unique case (cmd.kind)
					CMD_SEG: begin
						emit     = 1'b1;
						o_row    = 16'(row_coord);
						o_col    = 16'(col_q);
						o_len    = cmd.len;
						o_first  = cmd.v1;
						o_second = (cmd.len < 8'd2) ? 4'd0 : cmd.v2;
						col_d    = sat_add(col_q, cmd.len);
					end
					CMD_EOL, CMD_DY: begin
						if (cmd.kind == CMD_EOL)
							col_d = '0;
						line_d = line_step;
						if (step_ge) begin
							emit   = 1'b1;
							o_done = 1'b1;
							done_d = 1'b1;
						end
					end
					CMD_DX: col_d = sat_add(col_q, cmd.v1);
					CMD_DONE: begin
						emit   = 1'b1;
						o_done = 1'b1;
						done_d = 1'b1;
					end
					CMD_NOP: ;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			line_q    <= '0;
			done_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				col_q  <= col_d;
				line_q <= line_d;
				done_q <= done_d;
			end
			if (!out_vld_q || out_ready)
				out_vld_q <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_row_q    <= o_row;
			out_col_q    <= o_col;
			out_len_q    <= o_len;
			out_first_q  <= o_first;
			out_second_q <= o_second;
			out_done_q   <= o_done;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_row    = out_row_q;
	assign out_column = out_col_q;
	assign out_len    = out_len_q;
	assign out_first  = out_first_q;
	assign out_second = out_second_q;
	assign out_done   = out_done_q;

	// finished image stays finished until reset
	`BMPRLE_ASSERT_NEXT(a_done_sticky, clk, arst_n, done_q, done_q)
	// done marker carries an all-zero payload
	`BMPRLE_ASSERT_IMPL(a_done_payload, clk, arst_n, out_vld_q && out_done_q,
		out_row_q == 16'd0 && out_col_q == 16'd0 && out_len_q == 8'd0 && out_first_q == 8'd0)
	// nothing new is produced once decoding has finished
	`BMPRLE_ASSERT_NEXT(a_quiet_after_done, clk, arst_n, done_q && !out_vld_q, !out_vld_q)
	// a segment result never comes from a finished decoder
	`BMPRLE_ASSERT_IMPL(a_no_emit_done, clk, arst_n, pop && done_q, !emit)

endmodule

@@ hw/rtl/bmp_rle_pixel_decoder_unit.sv @@
// Channel  | dir | handshake          | payload
// s_*      | in  | s_tvalid/s_tready  | s_tdata: code_byte
// m_*      | out | m_tvalid/m_tready  | m_tdata: segment; m_tlast: done_res
// cfg_*    | in  | cfg_we             | cfg_index, cfg_data
// One byte per cycle sustained while the queue is not full; the front end classifies
// a byte combinationally in its accept cycle and writes the command into the two-entry
// queue at that edge. The back end pops it into the output register once that register
// is empty or being read, so a result passes through the queue and then that register.
// Reset is asynchronous, active low; no clearing pass, input is ready at once.
// s_tready drops only while the command queue is full (output stalled).
// Top level of the BMP RLE8/RLE4 pixel decoder; depends on bmprle_pkg,
// bmprle_front, bmprle_fifo and bmprle_back.
module bmp_rle_pixel_decoder_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,   // [7:0] code_byte
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [15:0] row, [31:16] column, [39:32] run_length, [47:40] first_value,
	// [51:48] second_value, [55:52] zero
	output logic [bmprle_pkg::OUT_DATA_BITS-1:0] m_tdata,
	output logic                                 m_tlast,   // done_res
	input  logic                                 cfg_we,
	input  logic [bmprle_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [15:0]                          cfg_data
);
	import bmprle_pkg::*;

	logic        nibble_mode_q;
	logic [15:0] image_height_q;
	logic        push, q_full, q_pop, q_valid;
	cmd_t        f_cmd, q_head;
	logic [15:0] o_row, o_col;
	logic [7:0]  o_len, o_first;
	logic [3:0]  o_second;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nibble_mode_q  <= 1'b0;
			image_height_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NIBBLE_MODE:  nibble_mode_q  <= cfg_data[0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	bmprle_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.code_byte   (s_tdata),
		.nibble_mode (nibble_mode_q),
		.cmd         (f_cmd)
	);

	bmprle_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (f_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	bmprle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd          (q_head),
		.pop          (q_pop),
		.image_height (image_height_q),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_row      (o_row),
		.out_column   (o_col),
		.out_len      (o_len),
		.out_first    (o_first),
		.out_second   (o_second),
		.out_done     (m_tlast)
	);

	assign m_tdata = {4'd0, o_second, o_first, o_len, o_col, o_row};

endmodule
